>>> rtl/acbl_pkg.sv
// ----------------------------------------------------------------------------
// acbl_pkg
// Shared widths, constants and helpers of the arm configuration labeler.
// ----------------------------------------------------------------------------
package acbl_pkg;

    // fixed point format of angles and lengths
    localparam int FRACTION_BITS = 16;
    localparam int ANGLE_W       = 20;
    localparam int LENGTH_W      = 18;
    localparam int LABEL_W       = 3;

    // j1 + j2 + j3 needs two more bits than one angle
    localparam int ANG_SUM_W = ANGLE_W + 2;

    // radians to turns: K = round(2^36 / (2*pi)), split for two narrow multiplies
    localparam logic [35:0] TURN_SCALE = 36'h28BE60DB9;
    localparam int TURN_SPLIT = 17;
    localparam int TURN_HI_W  = 36 - TURN_SPLIT;
    localparam logic [TURN_SPLIT-1:0] TURN_LO = TURN_SCALE[TURN_SPLIT-1:0];
    localparam logic [TURN_HI_W-1:0]  TURN_HI = TURN_SCALE[35:TURN_SPLIT];
    localparam int PP_W = ANG_SUM_W + TURN_HI_W + 1;

    localparam int PHASE_W     = 32;
    localparam int PHASE_SHIFT = FRACTION_BITS + 4;
    localparam int PHASE_SUM_W = PHASE_SHIFT + PHASE_W;

    // Q30 sine datapath
    localparam int Q30_SHIFT = 30;
    localparam int X_W       = Q30_SHIFT + 1;
    localparam int SIN_W     = 32;
    localparam logic [X_W-1:0] Q30_ONE = X_W'(1) << Q30_SHIFT;

    localparam logic signed [SIN_W-1:0] C1 = 32'sd1686629713;
    localparam logic signed [SIN_W-1:0] C3 = -32'sd693598660;
    localparam logic signed [SIN_W-1:0] C5 = 32'sd85569310;
    localparam logic signed [SIN_W-1:0] C7 = -32'sd5026991;
    localparam logic signed [SIN_W-1:0] C9 = 32'sd172271;

    // sanity bound on a finished sine (just above one in Q30)
    localparam logic signed [SIN_W-1:0] SIN_LIMIT = 32'sh4010_0000;

    localparam int TERM_W  = LENGTH_W + SIN_W;
    localparam int WAIST_W = TERM_W + 2;

    // sine lanes
    localparam int NUM_LANES        = 5;
    localparam int LANE_SHOULDER    = 0;  // cos(j1)
    localparam int LANE_ELBOW       = 1;  // cos(j1+j2)
    localparam int LANE_WRIST       = 2;  // sin(j1+j2+j3)
    localparam int LANE_ELBOW_FLAG  = 3;  // sin(j2)
    localparam int LANE_WRIST_FLAG  = 4;  // sin(j4)
    localparam logic [NUM_LANES-1:0] LANE_COS = 5'b00011;

    // pipeline stages
    localparam int ST_ANGLE        = 0;
    localparam int ST_PROD         = 1;
    localparam int ST_FOLD         = 2;
    localparam int ST_SQUARE       = 3;
    localparam int ST_HORNER_FIRST = 4;
    localparam int ST_HORNER_LAST  = 7;
    localparam int ST_SINE         = 8;
    localparam int ST_TERM         = 9;
    localparam int ST_LABEL        = 10;
    localparam int NUM_STAGES      = 11;

    // configuration register indexes
    localparam int REG_INDEX_W = 2;
    localparam logic [REG_INDEX_W-1:0] REG_UPPER_ARM    = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_FOREARM      = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_WRIST_OFFSET = 2'd2;

    typedef struct packed {
        logic elbow_nonneg;
        logic elbow_nonpos;
        logic wrist_nonneg;
        logic wrist_nonpos;
    } sign_flags_t;

    // floor(a * b / 2^30)
    function automatic logic signed [SIN_W-1:0] mul_q30(
        input logic [X_W-1:0]          a,
        input logic signed [SIN_W-1:0] b
    );
        logic signed [2*SIN_W-1:0] p;
        p = $signed({1'b0, a}) * b;
        return p[Q30_SHIFT+SIN_W-1:Q30_SHIFT];
    endfunction

    // floor(x * x / 2^30), x <= 2^30
    function automatic logic [X_W-1:0] square_q30(input logic [X_W-1:0] x);
        logic [2*X_W-1:0] p;
        p = x * x;
        return p[Q30_SHIFT +: X_W];
    endfunction

    // Horner coefficients after the C9 seed
    function automatic logic signed [SIN_W-1:0] horner_coef(input logic [1:0] step);
        logic signed [SIN_W-1:0] c;
        case (step)
            2'd0:    c = C7;
            2'd1:    c = C5;
            2'd2:    c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/arm_configuration_branch_label.sv
// ----------------------------------------------------------------------------
// arm_configuration_branch_label
// Labels one joint vector of a six-axis arm with its waist/elbow/wrist branch.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid/in_stall with the four joint angles (signed,
//   FRACTION_BITS fraction bits, radians). Output channel: out_valid/out_stall
//   with the 3-bit branch_label. A request moves when valid is high and stall
//   is low. Link lengths are written through cfg_we/cfg_index/cfg_data while
//   no request is in flight; an index past the wrist offset is ignored.
//   Each request passes the register stages below in order; out_valid
//   rises once it reaches the last one, the waist sum.
//   Throughput: one request per cycle while out_stall is low; the eleven
//   register stages (angle sums, split turn multiply, phase fold, square,
//   four Horner steps, final sine multiply, length products, waist sum)
//   each hold one request and five sine lanes run side by side.
//   Reset clears all valid bits and the length registers (lengths of zero
//   give a waist term of zero, labelled waist front).
//   When out_stall is held, requests keep advancing into empty stages; the
//   input is stalled only once every stage holds a request.
// ----------------------------------------------------------------------------
module arm_configuration_branch_label
    import acbl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [REG_INDEX_W-1:0]        cfg_index,
    input  logic [LENGTH_W-1:0]           cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ANGLE_W-1:0]     shoulder_angle,
    input  logic signed [ANGLE_W-1:0]     elbow_angle,
    input  logic signed [ANGLE_W-1:0]     wrist_one_angle,
    input  logic signed [ANGLE_W-1:0]     wrist_two_angle,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [LABEL_W-1:0]            branch_label
);

    // ------------------------------------------------------------------
    // Link length registers
    // ------------------------------------------------------------------
    logic signed [LENGTH_W-1:0] upper_arm_length_reg;
    logic signed [LENGTH_W-1:0] forearm_length_reg;
    logic signed [LENGTH_W-1:0] wrist_offset_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_length_reg    <= '0;
            forearm_length_reg      <= '0;
            wrist_offset_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPPER_ARM:    upper_arm_length_reg    <= cfg_data;
                REG_FOREARM:      forearm_length_reg      <= cfg_data;
                REG_WRIST_OFFSET: wrist_offset_length_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or the stage
    // after it advances, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[ST_LABEL];

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [ANG_SUM_W-1:0] ang_reg  [NUM_LANES];
    logic signed [ANG_SUM_W-1:0] ang_next [NUM_LANES];

    logic signed [PP_W-1:0] pp_hi_reg  [NUM_LANES];
    logic signed [PP_W-1:0] pp_lo_reg  [NUM_LANES];
    logic signed [PP_W-1:0] pp_hi_next [NUM_LANES];
    logic signed [PP_W-1:0] pp_lo_next [NUM_LANES];

    logic [X_W-1:0] x_reg  [ST_FOLD:ST_HORNER_LAST][NUM_LANES];
    logic [1:0]     q_reg  [ST_FOLD:ST_HORNER_LAST][NUM_LANES];
    logic [X_W-1:0] x_next [NUM_LANES];
    logic [1:0]     q_next [NUM_LANES];

    logic [X_W-1:0] y_reg  [ST_SQUARE:ST_HORNER_LAST-1][NUM_LANES];
    logic [X_W-1:0] y_next [NUM_LANES];

    logic signed [SIN_W-1:0] s_reg  [ST_HORNER_FIRST:ST_HORNER_LAST][NUM_LANES];
    logic signed [SIN_W-1:0] s_next [ST_HORNER_FIRST:ST_HORNER_LAST][NUM_LANES];

    logic signed [SIN_W-1:0] sin_reg  [NUM_LANES];
    logic signed [SIN_W-1:0] sin_next [NUM_LANES];

    logic signed [TERM_W-1:0] term_reg  [3];
    logic signed [TERM_W-1:0] term_next [3];
    sign_flags_t              flags_reg;
    sign_flags_t              flags_next;

    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;

    // stage 0: angle sums per lane
    always_comb
    begin
        ang_next[LANE_SHOULDER]   = ANG_SUM_W'(shoulder_angle);
        ang_next[LANE_ELBOW]      = ANG_SUM_W'(shoulder_angle) + ANG_SUM_W'(elbow_angle);
        ang_next[LANE_WRIST]      = ANG_SUM_W'(shoulder_angle) + ANG_SUM_W'(elbow_angle)
                                  + ANG_SUM_W'(wrist_one_angle);
        ang_next[LANE_ELBOW_FLAG] = ANG_SUM_W'(elbow_angle);
        ang_next[LANE_WRIST_FLAG] = ANG_SUM_W'(wrist_two_angle);
    end

    // stage 1: angle times turn scale, high and low halves of K
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            pp_hi_next[l] = ang_reg[l] * $signed({1'b0, TURN_HI});
            pp_lo_next[l] = ang_reg[l] * $signed({1'b0, TURN_LO});
        end
    end

    // stage 2: recombine, take the 32-bit phase, fold into one quadrant
    always_comb
    begin
        logic signed [PHASE_SUM_W-1:0] wide;
        logic [PHASE_W-1:0]            phase;
        logic [1:0]                    quad;
        logic [Q30_SHIFT-1:0]          frac;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            wide  = (PHASE_SUM_W'(pp_hi_reg[l]) <<< TURN_SPLIT) + PHASE_SUM_W'(pp_lo_reg[l]);
            phase = wide[PHASE_SUM_W-1 -: PHASE_W];
            // cosine is a quarter turn ahead
            quad  = phase[PHASE_W-1 -: 2] + {1'b0, LANE_COS[l]};
            frac  = phase[Q30_SHIFT-1:0];
            q_next[l] = quad;
            x_next[l] = quad[0] ? (Q30_ONE - X_W'(frac)) : X_W'(frac);
        end
    end

    // stage 3: x squared; stages 4..7: Horner steps; stage 8: times x, sign
    always_comb
    begin
        logic signed [SIN_W-1:0] prod;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            y_next[l] = square_q30(x_reg[ST_FOLD][l]);
            s_next[ST_HORNER_FIRST][l] = horner_coef(2'd0)
                                       + mul_q30(y_reg[ST_SQUARE][l], C9);
            for (int k = ST_HORNER_FIRST + 1; k <= ST_HORNER_LAST; k++)
            begin
                s_next[k][l] = horner_coef(2'(k - ST_HORNER_FIRST))
                             + mul_q30(y_reg[k-1][l], s_reg[k-1][l]);
            end
            prod = mul_q30(x_reg[ST_HORNER_LAST][l], s_reg[ST_HORNER_LAST][l]);
            sin_next[l] = q_reg[ST_HORNER_LAST][l][1] ? -prod : prod;
        end
    end

    // stage 9: length products and sign flags
    always_comb
    begin
        term_next[0] = upper_arm_length_reg    * sin_reg[LANE_SHOULDER];
        term_next[1] = forearm_length_reg      * sin_reg[LANE_ELBOW];
        term_next[2] = wrist_offset_length_reg * sin_reg[LANE_WRIST];

        flags_next.elbow_nonneg = !sin_reg[LANE_ELBOW_FLAG][SIN_W-1];
        flags_next.elbow_nonpos = sin_reg[LANE_ELBOW_FLAG][SIN_W-1]
                               || (sin_reg[LANE_ELBOW_FLAG] == '0);
        flags_next.wrist_nonneg = !sin_reg[LANE_WRIST_FLAG][SIN_W-1];
        flags_next.wrist_nonpos = sin_reg[LANE_WRIST_FLAG][SIN_W-1]
                               || (sin_reg[LANE_WRIST_FLAG] == '0);
    end

    // stage 10: waist sign picks the sense of the elbow and wrist flags
    always_comb
    begin
        logic signed [WAIST_W-1:0] waist;
        logic                      front;
        waist = WAIST_W'(term_reg[0]) + WAIST_W'(term_reg[1]) + WAIST_W'(term_reg[2]);
        front = !waist[WAIST_W-1];
        label_next[0] = front;
        label_next[1] = front ? flags_reg.elbow_nonneg : flags_reg.elbow_nonpos;
        label_next[2] = front ? flags_reg.wrist_nonpos : flags_reg.wrist_nonneg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (adv[ST_ANGLE])
            begin
                ang_reg[l] <= ang_next[l];
            end
            if (adv[ST_PROD])
            begin
                pp_hi_reg[l] <= pp_hi_next[l];
                pp_lo_reg[l] <= pp_lo_next[l];
            end
            if (adv[ST_FOLD])
            begin
                x_reg[ST_FOLD][l] <= x_next[l];
                q_reg[ST_FOLD][l] <= q_next[l];
            end
            for (int k = ST_FOLD + 1; k <= ST_HORNER_LAST; k++)
            begin
                if (adv[k])
                begin
                    x_reg[k][l] <= x_reg[k-1][l];
                    q_reg[k][l] <= q_reg[k-1][l];
                end
            end
            if (adv[ST_SQUARE])
            begin
                y_reg[ST_SQUARE][l] <= y_next[l];
            end
            for (int k = ST_SQUARE + 1; k <= ST_HORNER_LAST - 1; k++)
            begin
                if (adv[k])
                begin
                    y_reg[k][l] <= y_reg[k-1][l];
                end
            end
            for (int k = ST_HORNER_FIRST; k <= ST_HORNER_LAST; k++)
            begin
                if (adv[k])
                begin
                    s_reg[k][l] <= s_next[k][l];
                end
            end
            if (adv[ST_SINE])
            begin
                sin_reg[l] <= sin_next[l];
            end
        end
        if (adv[ST_TERM])
        begin
            term_reg[0] <= term_next[0];
            term_reg[1] <= term_next[1];
            term_reg[2] <= term_next[2];
            flags_reg   <= flags_next;
        end
        if (adv[ST_LABEL])
        begin
            label_reg <= label_next;
        end
    end

    assign branch_label = label_reg;

`ifndef SYNTHESIS
    // input stalls only with every stage occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled with an empty stage");

    // a request taken in with none leaving adds one occupied stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !(out_valid && !out_stall))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("request lost or duplicated on entry");

    // a request leaving with none entering frees one stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && !in_stall) && out_valid && !out_stall)
        |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("request lost or duplicated on exit");

    // folded offset stays within a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_FOLD] |-> (x_reg[ST_FOLD][LANE_WRIST] <= Q30_ONE))
        else $error("phase fold out of range");

    // finished sine stays near unit magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_SINE] |-> ((sin_reg[LANE_ELBOW_FLAG] <= SIN_LIMIT)
                             && (sin_reg[LANE_ELBOW_FLAG] >= -SIN_LIMIT)))
        else $error("sine out of range");
`endif

endmodule
